@@ sv/scic_pkg.sv @@
package scic_pkg;

    localparam int LINE_CAPACITY_DEF = 64;
    localparam int STRIP_PIXELS      = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARM     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 2'd3;

    localparam logic [19:0] TIMEOUT_RST  = 20'd5000;
    localparam logic [7:0]  WARM_RST     = 8'd26;
    localparam logic [7:0]  HOT_RST      = 8'd37;
    localparam logic [7:0]  MAX_TEMP_RST = 8'd125;

    localparam logic [19:0] IDLE_MAX       = 20'hFFFFF;
    localparam logic [7:0]  LOW_TEMP_LIMIT = 8'd40;
    localparam logic [8:0]  INT_SAT        = 9'd511;
    localparam logic [7:0]  WHOLE_SAT      = 8'd255;

    localparam logic [8:0] PWM_FULL = 9'd255;
    localparam logic [8:0] PWM_HIGH = 9'd200;
    localparam logic [8:0] PWM_MID  = 9'd150;
    localparam logic [8:0] PWM_LOW  = 9'd100;

    localparam logic [3:0] LIT_FULL = 4'(STRIP_PIXELS);
    localparam logic [3:0] LIT_HIGH = 4'd6;
    localparam logic [3:0] LIT_MID  = 4'd4;
    localparam logic [3:0] LIT_LOW  = 4'd2;
    localparam logic [3:0] LIT_MIN  = 4'd1;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;

    localparam logic [3:0] LAMP_NONE = 4'b0000;
    localparam logic [3:0] LAMP_G    = 4'b0001;
    localparam logic [3:0] LAMP_Y    = 4'b0010;
    localparam logic [3:0] LAMP_R    = 4'b0100;
    localparam logic [3:0] LAMP_B    = 4'b1000;

    localparam logic [1:0] MODE_DARK = 2'd0;
    localparam logic [1:0] MODE_BAR  = 2'd1;
    localparam logic [1:0] MODE_RED  = 2'd2;

    typedef enum logic [4:0] {
        PH_LEAD  = 5'b00001,
        PH_SIGN  = 5'b00010,
        PH_DIGIT = 5'b00100,
        PH_FRAC  = 5'b01000,
        PH_DONE  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [19:0] timeout_ticks;
        logic [7:0]  warm_threshold;
        logic [7:0]  hot_threshold;
        logic [7:0]  max_valid_temp;
    } cfg_t;

    typedef struct packed {
        logic       overflowed;
        logic       len_nz;
        logic       len_ge2;
        logic       len_ge3;
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] p2;
        logic       comma_seen;
        logic [8:0] int_accum;
        logic       int_negative;
        logic [7:0] temp_whole;
        logic       temp_frac_nonzero;
        logic       temp_negative;
    } line_info_t;

    typedef struct packed {
        logic       alarm_active;
        logic       strip_refresh;
        logic [3:0] strip_lit;
        logic [1:0] strip_mode;
        logic       buzzer_on;
        logic       red_lamp;
        logic       yellow_lamp;
        logic       green_lamp;
    } result_t;

endpackage

@@ sv/serial_command_indicator_controller.sv @@
// Serial command indicator controller.
// Input stream s_*: one item per received UART byte (s_tuser = 0, byte in
// s_tdata) or per time tick (s_tuser = 1). Every item gives exactly one
// result item on m_*: lamp and buzzer levels, strip mode and lit count, a
// strip refresh flag and the alarm flag, as they stand after that item.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// timeout ticks, 1 warm threshold, 2 hot threshold, 3 max valid temperature.
// cfg_ready is always high; write only while no item is in flight.
// An item is registered at the input, then evaluated combinationally into
// the output register, from which its result shows on m_*. Throughput: one
// item per cycle while m_tready is high, set by the single evaluation stage
// between the input register and the output register.
// When m_tready is low the result holds; the input register still takes one
// more item, and s_tready drops only while both registers are full.
// Reset clears the line, alarm, idle count, m_tvalid and lamp/strip state (not
// m_tdata), restores cfg defaults; the block accepts items right after reset.
module serial_command_indicator_controller #(
    parameter int LINE_CAPACITY = scic_pkg::LINE_CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // rx_byte[7:0]
    input  logic [0:0]                         s_tuser,   // action[0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // green_lamp[0], yellow_lamp[1], red_lamp[2], buzzer_on[3], strip_mode[5:4],
    // strip_lit[9:6], strip_refresh[10], alarm_active[11], zero fill[15:12]
    output logic [15:0]                        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [scic_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scic_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import scic_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic       in_action_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    cfg_t       cfg_reg, cfg_next;

    logic       out_free;
    logic       fire;
    logic       s_accept;
    line_info_t info;
    result_t    res;

    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'b0000, out_reg};

    always_comb
    begin
        in_valid_next = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TIMEOUT:  cfg_next.timeout_ticks  = cfg_data;
                CFG_WARM:     cfg_next.warm_threshold = cfg_data[7:0];
                CFG_HOT:      cfg_next.hot_threshold  = cfg_data[7:0];
                CFG_MAX_TEMP: cfg_next.max_valid_temp = cfg_data[7:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    scic_line_parser #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .action  (in_action_reg),
        .rx_byte (in_byte_reg),
        .info    (info)
    );

    scic_indicator_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .action  (in_action_reg),
        .rx_byte (in_byte_reg),
        .info    (info),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '{timeout_ticks:  TIMEOUT_RST,
                               warm_threshold: WARM_RST,
                               hot_threshold:  HOT_RST,
                               max_valid_temp: MAX_TEMP_RST};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_action_reg <= s_tuser[0];
            in_byte_reg   <= s_tdata;
        end
        if (fire)
        begin
            out_reg <= res;
        end
    end

endmodule

@@ sv/scic_line_parser.sv @@
module scic_line_parser #(
    parameter int LINE_CAPACITY = scic_pkg::LINE_CAPACITY_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic                  action,
    input  logic [7:0]            rx_byte,
    output scic_pkg::line_info_t  info
);
    import scic_pkg::*;

    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);

    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic [2:0][7:0]  prefix_reg, prefix_next;
    phase_t           phase_reg, phase_next;
    logic             comma_reg, comma_next;
    logic [8:0]       iacc_reg, iacc_next;
    logic             ineg_reg, ineg_next;
    logic [7:0]       tw_reg, tw_next;
    logic             tfr_reg, tfr_next;
    logic             tneg_reg, tneg_next;

    logic        is_eol;
    logic        is_print;
    logic        is_digit;
    logic        is_sign;
    logic        pre_num;
    logic [3:0]  dval;
    logic [12:0] iacc_mul;
    logic [11:0] tw_mul;
    logic        do_int;
    logic        do_flt;
    logic        pre_s;
    logic        pre_p;
    logic        pre_t;

    always_comb
    begin
        is_eol   = !action && (rx_byte == CH_LF || rx_byte == CH_CR);
        is_print = !action && rx_byte >= CH_SPACE && rx_byte <= CH_TILDE;
        is_digit = rx_byte >= CH_ZERO && rx_byte <= CH_NINE;
        is_sign  = rx_byte == CH_PLUS || rx_byte == CH_MINUS;
        pre_num  = phase_reg == PH_LEAD || phase_reg == PH_SIGN || phase_reg == PH_DIGIT;
        dval     = 4'(rx_byte - CH_ZERO);
        iacc_mul = 13'(iacc_reg) * 13'd10 + 13'(dval);
        tw_mul   = 12'(tw_reg) * 12'd10 + 12'(dval);
        pre_s    = prefix_reg[0] == CH_S && prefix_reg[1] == CH_COLON;
        pre_p    = prefix_reg[0] == CH_P && prefix_reg[1] == CH_COLON;
        pre_t    = prefix_reg[0] == CH_T && prefix_reg[1] == CH_COLON;

        len_next    = len_reg;
        ovf_next    = ovf_reg;
        prefix_next = prefix_reg;
        phase_next  = phase_reg;
        comma_next  = comma_reg;
        iacc_next   = iacc_reg;
        ineg_next   = ineg_reg;
        tw_next     = tw_reg;
        tfr_next    = tfr_reg;
        tneg_next   = tneg_reg;
        do_int      = 1'b0;
        do_flt      = 1'b0;

        if (fire && (is_eol || (is_print && !ovf_reg && len_reg >= LEN_LAST)))
        begin
            // drop the line; overflow marks it, line end clears the mark
            ovf_next    = !is_eol;
            len_next    = '0;
            prefix_next = '0;
            phase_next  = PH_LEAD;
            comma_next  = 1'b0;
            iacc_next   = '0;
            ineg_next   = 1'b0;
            tw_next     = '0;
            tfr_next    = 1'b0;
            tneg_next   = 1'b0;
        end
        else if (fire && is_print && !ovf_reg)
        begin
            if (len_reg < LEN_W'(3))
            begin
                prefix_next[len_reg[1:0]] = rx_byte;
            end
            len_next = len_reg + 1'b1;
            if (len_reg >= LEN_W'(2))
            begin
                if (pre_s)
                begin
                    if (comma_reg)
                    begin
                        do_flt = 1'b1;
                    end
                    else if (rx_byte == CH_COMMA)
                    begin
                        comma_next = 1'b1;
                        phase_next = PH_LEAD;
                    end
                    else
                    begin
                        do_int = 1'b1;
                    end
                end
                else if (pre_p)
                begin
                    do_int = 1'b1;
                end
                else if (pre_t)
                begin
                    do_flt = 1'b1;
                end
            end

            if (do_int)
            begin
                if (phase_reg == PH_LEAD && rx_byte == CH_SPACE)
                begin
                    phase_next = phase_reg;
                end
                else if (phase_reg == PH_LEAD && is_sign)
                begin
                    ineg_next  = rx_byte == CH_MINUS;
                    phase_next = PH_SIGN;
                end
                else if (pre_num && is_digit)
                begin
                    iacc_next  = (iacc_mul > 13'(INT_SAT)) ? INT_SAT : iacc_mul[8:0];
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end

            if (do_flt)
            begin
                if (phase_reg == PH_LEAD && rx_byte == CH_SPACE)
                begin
                    phase_next = phase_reg;
                end
                else if (phase_reg == PH_LEAD && is_sign)
                begin
                    tneg_next  = rx_byte == CH_MINUS;
                    phase_next = PH_SIGN;
                end
                else if (pre_num && is_digit)
                begin
                    tw_next    = (tw_mul > 12'(WHOLE_SAT)) ? WHOLE_SAT : tw_mul[7:0];
                    phase_next = PH_DIGIT;
                end
                else if (pre_num && rx_byte == CH_DOT)
                begin
                    phase_next = PH_FRAC;
                end
                else if (phase_reg == PH_FRAC && is_digit)
                begin
                    tfr_next = tfr_reg || (rx_byte != CH_ZERO);
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            prefix_reg <= '0;
            phase_reg  <= PH_LEAD;
            comma_reg  <= 1'b0;
            iacc_reg   <= '0;
            ineg_reg   <= 1'b0;
            tw_reg     <= '0;
            tfr_reg    <= 1'b0;
            tneg_reg   <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            prefix_reg <= prefix_next;
            phase_reg  <= phase_next;
            comma_reg  <= comma_next;
            iacc_reg   <= iacc_next;
            ineg_reg   <= ineg_next;
            tw_reg     <= tw_next;
            tfr_reg    <= tfr_next;
            tneg_reg   <= tneg_next;
        end
    end

    always_comb
    begin
        info.overflowed        = ovf_reg;
        info.len_nz            = len_reg != '0;
        info.len_ge2           = len_reg >= LEN_W'(2);
        info.len_ge3           = len_reg >= LEN_W'(3);
        info.p0                = prefix_reg[0];
        info.p1                = prefix_reg[1];
        info.p2                = prefix_reg[2];
        info.comma_seen        = comma_reg;
        info.int_accum         = iacc_reg;
        info.int_negative      = ineg_reg;
        info.temp_whole        = tw_reg;
        info.temp_frac_nonzero = tfr_reg;
        info.temp_negative     = tneg_reg;
    end

endmodule

@@ sv/scic_indicator_ctrl.sv @@
module scic_indicator_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 action,
    input  logic [7:0]           rx_byte,
    input  scic_pkg::line_info_t info,
    input  scic_pkg::cfg_t       cfg,
    output scic_pkg::result_t    res
);
    import scic_pkg::*;

    logic        alarm_reg, alarm_next;
    logic [19:0] idle_reg, idle_next;
    logic [3:0]  lamp_reg, lamp_next;
    logic [1:0]  mode_reg, mode_next;
    logic [3:0]  lit_reg, lit_next;
    logic        refresh;

    logic        is_eol;
    logic [8:0]  pwm;
    logic [3:0]  pwm_lit;
    logic [7:0]  tw;
    logic        tneg;
    logic        warm;
    logic        hot;
    logic [3:0]  temp_lamps;
    logic        cmd_off;
    logic        cmd_a1;
    logic        cmd_a0;
    logic        cmd_s;
    logic        cmd_p;
    logic        cmd_t;

    always_comb
    begin
        is_eol = !action && (rx_byte == CH_LF || rx_byte == CH_CR);

        pwm = info.int_negative ? 9'd0 : info.int_accum;
        if (pwm >= PWM_FULL)
        begin
            pwm_lit = LIT_FULL;
        end
        else if (pwm >= PWM_HIGH)
        begin
            pwm_lit = LIT_HIGH;
        end
        else if (pwm >= PWM_MID)
        begin
            pwm_lit = LIT_MID;
        end
        else if (pwm >= PWM_LOW)
        begin
            pwm_lit = LIT_LOW;
        end
        else
        begin
            pwm_lit = LIT_MIN;
        end

        tw   = info.temp_whole;
        tneg = 1'b0;
        if (info.temp_negative && (tw != 8'd0 || info.temp_frac_nonzero))
        begin
            if (tw > LOW_TEMP_LIMIT || (tw == LOW_TEMP_LIMIT && info.temp_frac_nonzero))
            begin
                tw = 8'd0;
            end
            else
            begin
                tneg = 1'b1;
            end
        end
        else if (tw > cfg.max_valid_temp
                 || (tw == cfg.max_valid_temp && info.temp_frac_nonzero))
        begin
            tw = 8'd0;
        end
        warm = !tneg && tw >= cfg.warm_threshold;
        hot  = !tneg && tw >= cfg.hot_threshold;
        if (!warm)
        begin
            temp_lamps = LAMP_G;
        end
        else if (!hot)
        begin
            temp_lamps = LAMP_G | LAMP_Y;
        end
        else
        begin
            temp_lamps = LAMP_G | LAMP_Y | LAMP_R;
        end

        cmd_off = (info.len_ge3 && info.p0 == CH_O && info.p1 == CH_F && info.p2 == CH_F)
                  || info.p0 == CH_ZERO;
        cmd_a1  = info.len_ge3 && info.p0 == CH_A && info.p1 == CH_COLON && info.p2 == CH_ONE;
        cmd_a0  = info.len_ge3 && info.p0 == CH_A && info.p1 == CH_COLON && info.p2 == CH_ZERO;
        cmd_s   = info.len_ge2 && info.p0 == CH_S && info.p1 == CH_COLON;
        cmd_p   = info.len_ge2 && info.p0 == CH_P && info.p1 == CH_COLON;
        cmd_t   = info.len_ge2 && info.p0 == CH_T && info.p1 == CH_COLON;

        alarm_next = alarm_reg;
        idle_next  = idle_reg;
        lamp_next  = lamp_reg;
        mode_next  = mode_reg;
        lit_next   = lit_reg;
        refresh    = 1'b0;

        if (fire && action)
        begin
            if (idle_reg != IDLE_MAX)
            begin
                idle_next = idle_reg + 1'b1;
            end
            if (alarm_reg && idle_next > cfg.timeout_ticks)
            begin
                alarm_next = 1'b0;
                lamp_next  = LAMP_NONE;
                mode_next  = MODE_DARK;
                lit_next   = 4'd0;
                refresh    = 1'b1;
            end
        end
        else if (fire && is_eol)
        begin
            idle_next = '0;
            if (!info.overflowed && info.len_nz)
            begin
                if (cmd_off)
                begin
                    alarm_next = 1'b0;
                    lamp_next  = LAMP_NONE;
                    mode_next  = MODE_DARK;
                    lit_next   = 4'd0;
                    refresh    = 1'b1;
                end
                else if (cmd_a1)
                begin
                    alarm_next = 1'b1;
                    lamp_next  = LAMP_G | LAMP_Y | LAMP_R | LAMP_B;
                    mode_next  = MODE_RED;
                    lit_next   = 4'd0;
                    refresh    = 1'b1;
                end
                else if (cmd_a0)
                begin
                    alarm_next = 1'b0;
                    lamp_next  = LAMP_G;
                    mode_next  = MODE_DARK;
                    lit_next   = 4'd0;
                    refresh    = 1'b1;
                end
                else if (!alarm_reg)
                begin
                    if (cmd_s)
                    begin
                        if (info.comma_seen)
                        begin
                            mode_next = MODE_BAR;
                            lit_next  = pwm_lit;
                            lamp_next = temp_lamps;
                            refresh   = 1'b1;
                        end
                    end
                    else if (cmd_p)
                    begin
                        mode_next = MODE_BAR;
                        lit_next  = pwm_lit;
                        refresh   = 1'b1;
                    end
                    else if (cmd_t)
                    begin
                        lamp_next = temp_lamps;
                    end
                end
            end
        end

        res.green_lamp    = lamp_next[0];
        res.yellow_lamp   = lamp_next[1];
        res.red_lamp      = lamp_next[2];
        res.buzzer_on     = lamp_next[3];
        res.strip_mode    = mode_next;
        res.strip_lit     = lit_next;
        res.strip_refresh = refresh;
        res.alarm_active  = alarm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_reg <= 1'b0;
            idle_reg  <= '0;
            lamp_reg  <= LAMP_NONE;
            mode_reg  <= MODE_DARK;
            lit_reg   <= '0;
        end
        else
        begin
            alarm_reg <= alarm_next;
            idle_reg  <= idle_next;
            lamp_reg  <= lamp_next;
            mode_reg  <= mode_next;
            lit_reg   <= lit_next;
        end
    end

endmodule

@@ dv/tb_serial_command_indicator_controller.sv @@
`timescale 1ns / 100ps

module tb_serial_command_indicator_controller;
    import scic_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 325;
    localparam int PHASE_COUNT     = 6;

    class indicator_scoreboard;
        logic [19:0] timeout_ticks;
        logic [7:0]  warm_level;
        logic [7:0]  hot_level;
        logic [7:0]  max_temp;
        int          line_len;
        bit          overflowed;
        bit          alarm;
        logic [7:0]  head [3];
        phase_t      phase;
        bit          comma_seen;
        int          int_mag;
        bit          int_neg;
        int          whole;
        bit          frac_nz;
        bit          temp_neg;
        int          idle_count;
        logic [3:0]  lamps;
        logic [1:0]  strip_mode;
        logic [3:0]  strip_lit;
        result_t     due [$];
        int          errors;
        int          checked;
        int          timeouts;

        function new();
            timeout_ticks = TIMEOUT_RST;
            warm_level    = WARM_RST;
            hot_level     = HOT_RST;
            max_temp      = MAX_TEMP_RST;
            clear_line();
            overflowed = 1'b0;
            alarm      = 1'b0;
            idle_count = 0;
            lamps      = LAMP_NONE;
            strip_mode = MODE_DARK;
            strip_lit  = 4'd0;
            errors     = 0;
            checked    = 0;
            timeouts   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_TIMEOUT:  timeout_ticks = val;
                CFG_WARM:     warm_level = val[7:0];
                CFG_HOT:      hot_level = val[7:0];
                CFG_MAX_TEMP: max_temp = val[7:0];
                default:      ;
            endcase
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void clear_line();
            line_len   = 0;
            head       = '{default: 8'h00};
            phase      = PH_LEAD;
            comma_seen = 1'b0;
            int_mag    = 0;
            int_neg    = 1'b0;
            whole      = 0;
            frac_nz    = 1'b0;
            temp_neg   = 1'b0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit early(phase_t p);
            return p == PH_LEAD || p == PH_SIGN || p == PH_DIGIT;
        endfunction

        function void scan_int(logic [7:0] c);
            if (phase == PH_LEAD && c == CH_SPACE)
                return;
            if (phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS))
            begin
                int_neg = (c == CH_MINUS);
                phase   = PH_SIGN;
            end
            else if (early(phase) && is_digit(c))
            begin
                int_mag = int_mag * 10 + (c - CH_ZERO);
                if (int_mag > INT_SAT)
                    int_mag = INT_SAT;
                phase = PH_DIGIT;
            end
            else
                phase = PH_DONE;
        endfunction

        function void scan_temp(logic [7:0] c);
            if (phase == PH_LEAD && c == CH_SPACE)
                return;
            if (phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS))
            begin
                temp_neg = (c == CH_MINUS);
                phase    = PH_SIGN;
            end
            else if (early(phase) && is_digit(c))
            begin
                whole = whole * 10 + (c - CH_ZERO);
                if (whole > WHOLE_SAT)
                    whole = WHOLE_SAT;
                phase = PH_DIGIT;
            end
            else if (early(phase) && c == CH_DOT)
                phase = PH_FRAC;
            else if (phase == PH_FRAC && is_digit(c))
            begin
                if (c != CH_ZERO)
                    frac_nz = 1'b1;
            end
            else
                phase = PH_DONE;
        endfunction

        function void apply_pwm();
            int p;
            p = int_neg ? 0 : int_mag;
            if (p >= PWM_FULL)
                strip_lit = LIT_FULL;
            else if (p >= PWM_HIGH)
                strip_lit = LIT_HIGH;
            else if (p >= PWM_MID)
                strip_lit = LIT_MID;
            else if (p >= PWM_LOW)
                strip_lit = LIT_LOW;
            else
                strip_lit = LIT_MIN;
            strip_mode = MODE_BAR;
        endfunction

        function void apply_temp();
            int w;
            bit neg;
            bit warm;
            bit hot;
            w   = whole;
            neg = 1'b0;
            if (temp_neg && (w > 0 || frac_nz))
            begin
                if (w > LOW_TEMP_LIMIT || (w == LOW_TEMP_LIMIT && frac_nz))
                    w = 0;
                else
                    neg = 1'b1;
            end
            else if (w > max_temp || (w == max_temp && frac_nz))
                w = 0;
            warm = !neg && w >= warm_level;
            hot  = !neg && w >= hot_level;
            if (!warm)
                lamps = LAMP_G;
            else if (!hot)
                lamps = LAMP_G | LAMP_Y;
            else
                lamps = LAMP_G | LAMP_Y | LAMP_R;
        endfunction

        function void take_char(logic [7:0] c);
            int idx;
            idx = line_len;
            if (idx < 3)
                head[idx] = c;
            line_len++;
            if (idx < 2)
                return;
            if (head[0] == CH_S && head[1] == CH_COLON)
            begin
                if (comma_seen)
                    scan_temp(c);
                else if (c == CH_COMMA)
                begin
                    comma_seen = 1'b1;
                    phase      = PH_LEAD;
                end
                else
                    scan_int(c);
            end
            else if (head[0] == CH_P && head[1] == CH_COLON)
                scan_int(c);
            else if (head[0] == CH_T && head[1] == CH_COLON)
                scan_temp(c);
        endfunction

        function bit run_line();
            bit has2;
            bit has3;
            has2 = line_len >= 2;
            has3 = line_len >= 3;
            if ((has3 && head[0] == CH_O && head[1] == CH_F && head[2] == CH_F)
                || head[0] == CH_ZERO)
            begin
                alarm      = 1'b0;
                lamps      = LAMP_NONE;
                strip_mode = MODE_DARK;
                strip_lit  = 4'd0;
                return 1'b1;
            end
            if (has3 && head[0] == CH_A && head[1] == CH_COLON && head[2] == CH_ONE)
            begin
                alarm      = 1'b1;
                lamps      = LAMP_G | LAMP_Y | LAMP_R | LAMP_B;
                strip_mode = MODE_RED;
                strip_lit  = 4'd0;
                return 1'b1;
            end
            if (has3 && head[0] == CH_A && head[1] == CH_COLON && head[2] == CH_ZERO)
            begin
                alarm      = 1'b0;
                lamps      = LAMP_G;
                strip_mode = MODE_DARK;
                strip_lit  = 4'd0;
                return 1'b1;
            end
            if (alarm)
                return 1'b0;
            if (has2 && head[0] == CH_S && head[1] == CH_COLON)
            begin
                if (!comma_seen)
                    return 1'b0;
                apply_pwm();
                apply_temp();
                return 1'b1;
            end
            if (has2 && head[0] == CH_P && head[1] == CH_COLON)
            begin
                apply_pwm();
                return 1'b1;
            end
            if (has2 && head[0] == CH_T && head[1] == CH_COLON)
                apply_temp();
            return 1'b0;
        endfunction

        function void note_item(bit act, logic [7:0] b);
            bit      refresh;
            result_t r;
            refresh = 1'b0;
            if (act)
            begin
                if (idle_count < IDLE_MAX)
                    idle_count++;
                if (alarm && idle_count > timeout_ticks)
                begin
                    alarm      = 1'b0;
                    lamps      = LAMP_NONE;
                    strip_mode = MODE_DARK;
                    strip_lit  = 4'd0;
                    refresh    = 1'b1;
                    timeouts++;
                end
            end
            else if (b == CH_LF || b == CH_CR)
            begin
                idle_count = 0;
                if (overflowed)
                    overflowed = 1'b0;
                else if (line_len > 0)
                    refresh = run_line();
                clear_line();
            end
            else if (b >= CH_SPACE && b <= CH_TILDE && !overflowed)
            begin
                if (line_len < LINE_CAPACITY_DEF - 1)
                    take_char(b);
                else
                begin
                    overflowed = 1'b1;
                    clear_line();
                end
            end
            r.green_lamp    = lamps[0];
            r.yellow_lamp   = lamps[1];
            r.red_lamp      = lamps[2];
            r.buzzer_on     = lamps[3];
            r.strip_mode    = strip_mode;
            r.strip_lit     = strip_lit;
            r.strip_refresh = refresh;
            r.alarm_active  = alarm;
            due.push_back(r);
        endfunction

        function bit field_differs(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_result(logic [15:0] data);
            result_t got;
            result_t want;
            bit      bad;
            got = data[11:0];
            bad = 1'b0;
            checked++;
            if (due.size() == 0)
            begin
                $display("%0t result %h with none expected", $time, data);
                errors++;
                return;
            end
            want = due.pop_front();
            bad |= field_differs("green_lamp", want.green_lamp, got.green_lamp);
            bad |= field_differs("yellow_lamp", want.yellow_lamp, got.yellow_lamp);
            bad |= field_differs("red_lamp", want.red_lamp, got.red_lamp);
            bad |= field_differs("buzzer_on", want.buzzer_on, got.buzzer_on);
            bad |= field_differs("strip_mode", want.strip_mode, got.strip_mode);
            bad |= field_differs("strip_lit", want.strip_lit, got.strip_lit);
            bad |= field_differs("strip_refresh", want.strip_refresh, got.strip_refresh);
            bad |= field_differs("alarm_active", want.alarm_active, got.alarm_active);
            if (bad)
                errors++;
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    indicator_scoreboard sb;
    bit                  idle_ok;
    int                  items_sent;
    int                  lines_sent;
    int                  settings_used;
    logic [7:0]          line_q [$];

    serial_command_indicator_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : result_sink
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else if (idle_ok && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("serial_command_indicator_controller: mismatch");
        $finish;
    end

    task automatic send_item(input bit act, input logic [7:0] b);
        if (idle_ok && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(act, b);
        items_sent++;
    endtask

    // hold the sender until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic write_settings(input logic [19:0] tmo, input logic [7:0] warm,
                                  input logic [7:0] hot, input logic [7:0] maxt);
        cfg_put(CFG_TIMEOUT, tmo);
        cfg_put(CFG_WARM, {12'($urandom), warm});
        cfg_put(CFG_HOT, {12'($urandom), hot});
        cfg_put(CFG_MAX_TEMP, {12'($urandom), maxt});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] v;
        v = 8'($urandom);
        while (v == CH_LF || v == CH_CR || (v >= CH_SPACE && v <= CH_TILDE))
            v = 8'($urandom);
        return v;
    endfunction

    function automatic string int_text();
        string s;
        int    v;
        s = "";
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) s = {s, " "};
        case ($urandom_range(0, 5))
            0:       s = {s, "-"};
            1:       s = {s, "+"};
            default: ;
        endcase
        case ($urandom_range(0, 15))
            0:       v = 0;
            1:       v = 99;
            2:       v = 100;
            3:       v = 149;
            4:       v = 150;
            5:       v = 199;
            6:       v = 200;
            7:       v = 254;
            8:       v = 255;
            9:       v = 511;
            10:      v = 512;
            11:      v = $urandom_range(600, 99999);
            default: v = $urandom_range(0, 300);
        endcase
        if ($urandom_range(0, 7) == 0)
            s = {s, "00"};
        if ($urandom_range(0, 11) != 0)
            s = {s, $sformatf("%0d", v)};
        case ($urandom_range(0, 9))
            0:       s = {s, "x9"};
            1:       s = {s, " 7"};
            2:       s = {s, "-"};
            default: ;
        endcase
        return s;
    endfunction

    function automatic string temp_text();
        string s;
        int    w;
        s = "";
        if ($urandom_range(0, 19) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return "inf";
                1:       return "nan";
                2:       return "0x1F";
                default: return "-inf";
            endcase
        end
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) s = {s, " "};
        case ($urandom_range(0, 3))
            0, 1:    s = {s, "-"};
            2:       s = {s, "+"};
            default: ;
        endcase
        case ($urandom_range(0, 19))
            0:       w = 0;
            1:       w = 39;
            2:       w = 40;
            3:       w = 41;
            4:       w = int'(sb.warm_level) + $urandom_range(0, 2) - 1;
            5:       w = int'(sb.hot_level) + $urandom_range(0, 2) - 1;
            6:       w = int'(sb.max_temp) + $urandom_range(0, 2) - 1;
            7:       w = 255;
            8:       w = 256;
            9:       w = $urandom_range(300, 9999);
            10:      w = -1;
            default: w = $urandom_range(0, 130);
        endcase
        if (w >= 0)
            s = {s, $sformatf("%0d", w)};
        case ($urandom_range(0, 7))
            0:       s = {s, "."};
            1:       s = {s, ".0"};
            2:       s = {s, ".00"};
            3:       s = {s, ".5"};
            4:       s = {s, ".05"};
            5:       s = {s, $sformatf(".%0d", $urandom_range(0, 999))};
            default: ;
        endcase
        case ($urandom_range(0, 11))
            0:       s = {s, "e2"};
            1:       s = {s, ".7"};
            2:       s = {s, "x"};
            3:       s = {s, ",3"};
            default: ;
        endcase
        return s;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    task automatic flush_line();
        foreach (line_q[i])
            send_item(1'b0, line_q[i]);
        line_q.delete();
    endtask

    task automatic finish_line();
        if ($urandom_range(0, 9) == 0)
            line_q.insert($urandom_range(0, line_q.size()), noise_byte());
        case ($urandom_range(0, 7))
            0:
            begin
                line_q.push_back(CH_CR);
                line_q.push_back(CH_LF);
            end
            1, 2, 3: line_q.push_back(CH_CR);
            default: line_q.push_back(CH_LF);
        endcase
        flush_line();
        lines_sent++;
    endtask

    task automatic tick_burst();
        int n;
        if (sb.timeout_ticks < 40)
            n = $urandom_range(1, int'(sb.timeout_ticks) + 3);
        else
            n = $urandom_range(1, 12);
        repeat (n) send_item(1'b1, 8'($urandom));
    endtask

    task automatic random_step();
        int k;
        int n;
        k = $urandom_range(0, 99);
        if (k >= 89)
        begin
            tick_burst();
            return;
        end
        if (k >= 85)
        begin
            repeat ($urandom_range(1, 6)) send_item(1'b0, noise_byte());
            return;
        end
        if (k < 25)
            push_text({"S:", int_text(), ",", temp_text()});
        else if (k < 37)
            push_text({"P:", int_text()});
        else if (k < 52)
            push_text({"T:", temp_text()});
        else if (k < 60)
            push_text($urandom_range(0, 3) == 0 ? "A:1 go" : "A:1");
        else if (k < 65)
            push_text("A:0");
        else if (k < 70)
        begin
            case ($urandom_range(0, 4))
                0:       push_text("OFF");
                1:       push_text("OFFLINE");
                2:       push_text("0");
                3:       push_text("0x");
                default: push_text("OF");
            endcase
        end
        else if (k < 73)
            push_text({"S:", int_text()});
        else if (k < 79 && k >= 76)
        begin
            // lengths around the line capacity
            case ($urandom_range(0, 4))
                0:       n = LINE_CAPACITY_DEF - 2;
                1:       n = LINE_CAPACITY_DEF - 1;
                2:       n = LINE_CAPACITY_DEF;
                3:       n = LINE_CAPACITY_DEF + 1;
                default: n = LINE_CAPACITY_DEF + 25;
            endcase
            push_text($urandom_range(0, 1) ? "P:200" : "A:1");
            while (line_q.size() < n)
                line_q.push_back(8'($urandom_range(32, 126)));
        end
        else if (k >= 79)
        begin
            case ($urandom_range(0, 6))
                0:       push_text("s:1,2");
                1:       push_text("P;5");
                2:       push_text("T 3");
                3:       push_text("A:2");
                4:       push_text("S:,");
                5:       push_text("A:");
                default:
                    repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(32, 126)));
            endcase
        end
        finish_line();
        if (k >= 52 && k < 60 && $urandom_range(0, 1) == 1)
            tick_burst();
    endtask

    initial
    begin : stimulus
        int target;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_TIMEOUT;
        cfg_data      = '0;
        idle_ok       = 1'b1;
        items_sent    = 0;
        lines_sent    = 0;
        settings_used = 1;
        sb            = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_text("A:1\r");
        flush_line();
        send_item(1'b1, 8'hA5);
        push_text("A:0\n0\nT:-40.5\nP:-9\n");
        flush_line();
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                case (ph)
                    1:       write_settings(20'd1, 8'd0, 8'd255, 8'd255);
                    2:       write_settings(20'd1000000, 8'd255, 8'd0, 8'd0);
                    3:       write_settings(20'd3, 8'd30, 8'd30, 8'd40);
                    4:       write_settings(20'($urandom_range(1, 60)), 8'($urandom),
                                            8'($urandom), 8'($urandom));
                    default: write_settings(20'd12, WARM_RST, HOT_RST, MAX_TEMP_RST);
                endcase
            end
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                idle_ok = (ph < PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
                random_step();
                if (items_sent >= target - ITEMS_PER_PHASE / 2
                    && items_sent < target - ITEMS_PER_PHASE / 2 + 8)
                    drain();
            end
        end
        drain();
        repeat (8) @(posedge clk);

        $display("%0d items, %0d lines, %0d results checked, %0d alarm timeouts",
                 items_sent, lines_sent, sb.checked, sb.timeouts);
        $display("%0d register settings incl. swapped and extreme thresholds", settings_used);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("serial_command_indicator_controller: match");
        else
            $display("serial_command_indicator_controller: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/scic_pkg.sv
sv/scic_line_parser.sv
sv/scic_indicator_ctrl.sv
sv/serial_command_indicator_controller.sv
dv/tb_serial_command_indicator_controller.sv
